// ===== rtl/core/tsk_pkg.sv =====
// ----------------------------------------------------------------------------
// tsk_pkg
// Shared types and constants of the topological sorter: operation and result
// codes, controller states and the result item layout.
// ----------------------------------------------------------------------------
package tsk_pkg;

  localparam int unsigned NODE_COUNT_DEF    = 16;
  localparam int unsigned EDGE_CAPACITY_DEF = 64;

  localparam int unsigned OP_W   = 2;
  localparam int unsigned NODE_W = 4;
  localparam int unsigned KIND_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_ADD_NODE = 2'd0,
    OP_ADD_EDGE = 2'd1,
    OP_SORT     = 2'd2
  } op_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_ACK    = 2'd0,
    KIND_ORDER  = 2'd1,
    KIND_STATUS = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COPY,
    ST_POP,
    ST_SCAN,
    ST_DEGREE,
    ST_STATUS
  } state_e;

  typedef struct packed {
    kind_e             kind;
    logic [NODE_W-1:0] node_index;
    logic              accepted;
    logic              cyclic;
    logic              is_last;
  } result_t;

endpackage

// ===== rtl/core/tsk_in_if.sv =====
// ----------------------------------------------------------------------------
// tsk_in_if
// Command channel of the topological sorter: operation and node operands.
// ----------------------------------------------------------------------------
interface tsk_in_if import tsk_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [NODE_W-1:0] node_a;
  logic [NODE_W-1:0] node_b;

  modport source (output valid, output operation, output node_a, output node_b,
                  input ready);
  modport sink   (input valid, input operation, input node_a, input node_b,
                  output ready);
endinterface

// ===== rtl/core/tsk_out_if.sv =====
// ----------------------------------------------------------------------------
// tsk_out_if
// Result channel of the topological sorter: acks, order entries and status.
// ----------------------------------------------------------------------------
interface tsk_out_if import tsk_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [NODE_W-1:0] node_index;
  logic              accepted;
  logic              cyclic;
  logic              is_last;

  modport source (output valid, output kind, output node_index, output accepted,
                  output cyclic, output is_last, input ready);
  modport sink   (input valid, input kind, input node_index, input accepted,
                  input cyclic, input is_last, output ready);
endinterface

// ===== rtl/core/topological_sort_kahn.sv =====
// ----------------------------------------------------------------------------
// topological_sort_kahn
// Graph store and Kahn sorter with a LIFO ready stack.
//
// in_i takes one command item per handshake: add node, add edge or run sort.
// out_o returns result items through a two-entry output queue, so a new
// command is taken while one finished result still waits to be taken.
// An add gives one ack item, which the output queue shows in the cycle after
// the add is taken; adds run one a cycle as long as the receiver keeps up.
// A sort first copies the in-degree table into the work-degree memory, one
// node a cycle, pushing ready nodes. Each popped node is sent as an order
// item in ST_POP, then ST_SCAN reads every stored edge; each edge leaving
// that node adds an ST_DEGREE step (read-modify-write of the work-degree
// memory). On finding the stack empty, ST_STATUS sends the status item.
// Commands are held off for the whole sort. A stalled receiver simply
// freezes the sorter once the queue is full.
// Reset clears the node table, the in-degrees, the edge count and the queue;
// the edge and work-degree memories need no clearing pass.
// ----------------------------------------------------------------------------
module topological_sort_kahn import tsk_pkg::*; #(
  parameter int unsigned NODE_COUNT    = NODE_COUNT_DEF,
  parameter int unsigned EDGE_CAPACITY = EDGE_CAPACITY_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tsk_in_if.sink    in_i,
  tsk_out_if.source out_o
);

  localparam int unsigned NW = $clog2(NODE_COUNT);
  localparam int unsigned AW = (NW > NODE_W) ? NW : NODE_W;
  localparam int unsigned CW = AW + 1;
  localparam int unsigned SW = $clog2(NODE_COUNT + 1);
  localparam int unsigned EW = (EDGE_CAPACITY > 1) ? $clog2(EDGE_CAPACITY) : 1;
  localparam int unsigned TW = $clog2(EDGE_CAPACITY + 1);
  localparam int unsigned DW = TW;

  function automatic logic [NW-1:0] to_idx(input logic [NODE_W-1:0] n);
    logic [AW-1:0] ext;
    ext = AW'(n);
    return ext[NW-1:0];
  endfunction

  function automatic logic in_range(input logic [NODE_W-1:0] n);
    return CW'(n) < CW'(NODE_COUNT);
  endfunction

  state_e              state_q, state_d;
  logic                present_q [NODE_COUNT];
  logic [DW-1:0]       indeg_q   [NODE_COUNT];
  logic [SW-1:0]       pres_cnt_q, pres_cnt_d;
  logic [TW-1:0]       edge_total_q, edge_total_d;
  logic [SW-1:0]       emit_cnt_q, emit_cnt_d;
  logic [SW-1:0]       depth_q, depth_d;
  logic [NW-1:0]       copy_q, copy_d;
  logic [TW-1:0]       idx_q, idx_d;
  logic [NODE_W-1:0]   cur_q, cur_d;

  // edge store and work degrees, synchronous read
  logic [2*NODE_W-1:0] edge_mem [EDGE_CAPACITY];
  logic [2*NODE_W-1:0] edge_rdata_q;
  logic [EW-1:0]       edge_raddr;
  logic                edge_we;
  logic [DW-1:0]       wd_mem [NODE_COUNT];
  logic [DW-1:0]       wd_rdata_q;
  logic [NW-1:0]       wd_raddr, wd_waddr;
  logic [DW-1:0]       wd_wdata;
  logic                wd_we;

  logic [NODE_W-1:0]   stack_q [NODE_COUNT];
  logic                push_en;
  logic [NODE_W-1:0]   push_node;

  logic                present_set, indeg_inc;
  logic [NW-1:0]       deg_addr;
  logic [DW-1:0]       deg_val;

  result_t             fifo_q [2];
  logic                fifo_wr_q, fifo_rd_q;
  logic [1:0]          fifo_cnt_q;
  logic                fifo_push, fifo_pop, fifo_space;
  result_t             fifo_item;

  logic                in_acc;
  logic [NW-1:0]       a_idx, b_idx;
  logic [NODE_W-1:0]   e_src, e_tgt;
  logic                ok;

  assign a_idx      = to_idx(in_i.node_a);
  assign b_idx      = to_idx(in_i.node_b);
  assign e_src      = edge_rdata_q[2*NODE_W-1:NODE_W];
  assign e_tgt      = edge_rdata_q[NODE_W-1:0];
  assign fifo_space = (fifo_cnt_q != 2'd2);
  assign in_i.ready = (state_q == ST_IDLE) && fifo_space;
  assign in_acc     = in_i.valid && in_i.ready;

  assign deg_addr   = (state_q == ST_COPY) ? copy_q : b_idx;
  assign deg_val    = indeg_q[deg_addr];
  assign wd_raddr   = to_idx(e_tgt);
  assign edge_raddr = (idx_d < TW'(EDGE_CAPACITY)) ? idx_d[EW-1:0] : '0;

  always_comb begin
    state_d      = state_q;
    pres_cnt_d   = pres_cnt_q;
    edge_total_d = edge_total_q;
    emit_cnt_d   = emit_cnt_q;
    depth_d      = depth_q;
    copy_d       = copy_q;
    idx_d        = idx_q;
    cur_d        = cur_q;
    edge_we      = 1'b0;
    wd_we        = 1'b0;
    wd_waddr     = copy_q;
    wd_wdata     = deg_val;
    push_en      = 1'b0;
    push_node    = NODE_W'(copy_q);
    present_set  = 1'b0;
    indeg_inc    = 1'b0;
    fifo_push    = 1'b0;
    fifo_item    = '{kind: KIND_ACK, node_index: '0, accepted: 1'b0,
                     cyclic: 1'b0, is_last: 1'b1};
    ok           = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_i.operation)
            OP_ADD_NODE: begin
              ok        = in_range(in_i.node_a);
              fifo_push = 1'b1;
              if (ok) begin
                present_set = 1'b1;
                if (!present_q[a_idx]) begin
                  pres_cnt_d = pres_cnt_q + SW'(1);
                end
              end
            end
            OP_ADD_EDGE: begin
              ok = in_range(in_i.node_a) && in_range(in_i.node_b) &&
                   present_q[a_idx] && present_q[b_idx] &&
                   (edge_total_q < TW'(EDGE_CAPACITY));
              fifo_push = 1'b1;
              if (ok) begin
                edge_we      = 1'b1;
                indeg_inc    = 1'b1;
                edge_total_d = edge_total_q + TW'(1);
              end
            end
            OP_SORT: begin
              depth_d    = '0;
              emit_cnt_d = '0;
              copy_d     = '0;
              state_d    = ST_COPY;
            end
            default: begin
              fifo_push = 1'b1;
            end
          endcase
          fifo_item.accepted = ok;
        end
      end
      ST_COPY: begin
        wd_we = 1'b1;
        if (present_q[copy_q] && (deg_val == '0) && (depth_q < SW'(NODE_COUNT))) begin
          push_en = 1'b1;
          depth_d = depth_q + SW'(1);
        end
        if (copy_q == NW'(NODE_COUNT - 1)) begin
          state_d = ST_POP;
        end else begin
          copy_d = copy_q + NW'(1);
        end
      end
      ST_POP: begin
        if (depth_q == '0) begin
          state_d = ST_STATUS;
        end else if (fifo_space) begin
          cur_d                = stack_q[NW'(depth_q - SW'(1))];
          fifo_push            = 1'b1;
          fifo_item.kind       = KIND_ORDER;
          fifo_item.node_index = cur_d;
          fifo_item.is_last    = 1'b0;
          depth_d              = depth_q - SW'(1);
          emit_cnt_d           = emit_cnt_q + SW'(1);
          idx_d                = '0;
          state_d              = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // edge read data register holds the edge at idx_q
        if (idx_q == edge_total_q) begin
          state_d = ST_POP;
        end else if ((e_src == cur_q) && in_range(e_tgt)) begin
          state_d = ST_DEGREE;
        end else begin
          idx_d = idx_q + TW'(1);
        end
      end
      ST_DEGREE: begin
        if (wd_rdata_q != '0) begin
          wd_we    = 1'b1;
          wd_waddr = to_idx(e_tgt);
          wd_wdata = wd_rdata_q - DW'(1);
          if ((wd_rdata_q == DW'(1)) && (depth_q < SW'(NODE_COUNT))) begin
            push_en   = 1'b1;
            push_node = e_tgt;
            depth_d   = depth_q + SW'(1);
          end
        end
        idx_d   = idx_q + TW'(1);
        state_d = ST_SCAN;
      end
      ST_STATUS: begin
        if (fifo_space) begin
          // a present node never pushed still holds a nonzero degree
          fifo_push        = 1'b1;
          fifo_item.kind   = KIND_STATUS;
          fifo_item.cyclic = (emit_cnt_q != pres_cnt_q);
          state_d          = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign fifo_pop = out_o.valid && out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      pres_cnt_q   <= '0;
      edge_total_q <= '0;
      emit_cnt_q   <= '0;
      depth_q      <= '0;
      copy_q       <= '0;
      idx_q        <= '0;
      cur_q        <= '0;
      fifo_wr_q    <= 1'b0;
      fifo_rd_q    <= 1'b0;
      fifo_cnt_q   <= '0;
      for (int i = 0; i < NODE_COUNT; i++) begin
        present_q[i] <= 1'b0;
        indeg_q[i]   <= '0;
      end
    end else begin
      state_q      <= state_d;
      pres_cnt_q   <= pres_cnt_d;
      edge_total_q <= edge_total_d;
      emit_cnt_q   <= emit_cnt_d;
      depth_q      <= depth_d;
      copy_q       <= copy_d;
      idx_q        <= idx_d;
      cur_q        <= cur_d;
      if (present_set) begin
        present_q[a_idx] <= 1'b1;
      end
      if (indeg_inc) begin
        indeg_q[b_idx] <= deg_val + DW'(1);
      end
      if (fifo_push) begin
        fifo_wr_q <= ~fifo_wr_q;
      end
      if (fifo_pop) begin
        fifo_rd_q <= ~fifo_rd_q;
      end
      fifo_cnt_q <= fifo_cnt_q + 2'(fifo_push) - 2'(fifo_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (edge_we) begin
      edge_mem[edge_total_q[EW-1:0]] <= {in_i.node_a, in_i.node_b};
    end
    edge_rdata_q <= edge_mem[edge_raddr];
    if (wd_we) begin
      wd_mem[wd_waddr] <= wd_wdata;
    end
    wd_rdata_q <= wd_mem[wd_raddr];
    if (push_en) begin
      stack_q[depth_q[NW-1:0]] <= push_node;
    end
    if (fifo_push) begin
      fifo_q[fifo_wr_q] <= fifo_item;
    end
  end

  assign out_o.valid      = (fifo_cnt_q != '0);
  assign out_o.kind       = fifo_q[fifo_rd_q].kind;
  assign out_o.node_index = fifo_q[fifo_rd_q].node_index;
  assign out_o.accepted   = fifo_q[fifo_rd_q].accepted;
  assign out_o.cyclic     = fifo_q[fifo_rd_q].cyclic;
  assign out_o.is_last    = fifo_q[fifo_rd_q].is_last;

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Kahn topological sorter. A short table of
// commands opens the run, then random graphs are built and sorted. Every
// accepted command is run through a local graph model, and each result item
// is compared with the oldest expected one. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_top;
  import tsk_pkg::*;

  localparam int unsigned RESET_CYCLES = 12;
  localparam int unsigned RANDOM_ITEMS = 450;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned CHOKE_AFTER  = 120;
  localparam int unsigned CHOKE_CYCLES = 300;
  // covers the worst sort, plus 17 results behind long stalls
  localparam int unsigned CYCLE_LIMIT  = 4_000_000;

  localparam logic [OP_W-1:0]   OP_UNKNOWN = 2'd3;
  // node that carries the self loop; random well-formed edges keep clear of it
  localparam logic [NODE_W-1:0] LOOP_NODE  = 4'd10;

  localparam result_t ACK_TAKEN = '{kind: KIND_ACK, node_index: '0, accepted: 1'b1,
                                    cyclic: 1'b0, is_last: 1'b1};
  localparam result_t ACK_REFUSED = '{kind: KIND_ACK, node_index: '0, accepted: 1'b0,
                                      cyclic: 1'b0, is_last: 1'b1};
  localparam result_t STATUS_ACYCLIC = '{kind: KIND_STATUS, node_index: '0, accepted: 1'b0,
                                         cyclic: 1'b0, is_last: 1'b1};

  typedef result_t result_q_t [$];

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [NODE_W-1:0] a;
    logic [NODE_W-1:0] b;
    bit                typed;
    result_t           want;
  } cmd_row_t;

  logic clk_i;
  logic rst_ni;

  tsk_in_if  cmd_if ();
  tsk_out_if res_if ();

  topological_sort_kahn dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_if),
    .out_o  (res_if)
  );

  // graph model
  logic              node_seen [NODE_COUNT_DEF] = '{default: 1'b0};
  int unsigned       indegree  [NODE_COUNT_DEF] = '{default: 0};
  logic [NODE_W-1:0] edge_from [$];
  logic [NODE_W-1:0] edge_to   [$];
  logic [NODE_W-1:0] topo_rank [NODE_COUNT_DEF];

  result_t     pending_results [$];
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt    = 0;
  bit          calm_tx      = 1'b0;

  cmd_row_t directed_rows [21] = '{
    '{OP_SORT,     4'd0,      4'd0,      1'b1, STATUS_ACYCLIC}, // empty graph
    '{OP_ADD_EDGE, 4'd0,      4'd15,     1'b1, ACK_REFUSED},    // both ends absent
    '{OP_UNKNOWN,  4'd15,     4'd15,     1'b1, ACK_REFUSED},
    '{OP_ADD_NODE, 4'd0,      4'd0,      1'b1, ACK_TAKEN},
    '{OP_ADD_NODE, 4'd15,     4'd15,     1'b1, ACK_TAKEN},
    '{OP_ADD_NODE, 4'd15,     4'd0,      1'b1, ACK_TAKEN},      // same node again
    '{OP_ADD_EDGE, 4'd0,      4'd5,      1'b1, ACK_REFUSED},    // target absent
    '{OP_ADD_EDGE, 4'd5,      4'd0,      1'b1, ACK_REFUSED},    // source absent
    '{OP_ADD_EDGE, 4'd0,      4'd15,     1'b0, ACK_REFUSED},
    '{OP_SORT,     4'd0,      4'd0,      1'b0, ACK_REFUSED},
    '{OP_ADD_NODE, 4'd5,      4'd0,      1'b1, ACK_TAKEN},
    '{OP_ADD_NODE, LOOP_NODE, 4'd0,      1'b1, ACK_TAKEN},
    '{OP_ADD_NODE, 4'd3,      4'd0,      1'b1, ACK_TAKEN},
    '{OP_ADD_EDGE, 4'd15,     4'd5,      1'b0, ACK_REFUSED},
    '{OP_ADD_EDGE, 4'd0,      4'd5,      1'b0, ACK_REFUSED},
    '{OP_ADD_EDGE, 4'd0,      4'd5,      1'b0, ACK_REFUSED},    // duplicate edge
    '{OP_ADD_EDGE, 4'd3,      4'd15,     1'b0, ACK_REFUSED},
    '{OP_SORT,     4'd15,     4'd15,     1'b0, ACK_REFUSED},
    '{OP_ADD_EDGE, LOOP_NODE, LOOP_NODE, 1'b0, ACK_REFUSED},    // self loop
    '{OP_SORT,     4'd0,      4'd0,      1'b0, ACK_REFUSED},    // cycle from here on
    '{OP_UNKNOWN,  4'd0,      4'd0,      1'b1, ACK_REFUSED}
  };

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic result_t mk_result(kind_e k, logic [NODE_W-1:0] n, logic acc,
                                        logic cyc, logic last);
    result_t r;
    r.kind       = k;
    r.node_index = n;
    r.accepted   = acc;
    r.cyclic     = cyc;
    r.is_last    = last;
    return r;
  endfunction

  // applies one command to the graph model and returns the result items it gives
  function automatic void kahn_predict(input logic [OP_W-1:0] op,
                                       input logic [NODE_W-1:0] a, b,
                                       output result_q_t res);
    int unsigned       rem [NODE_COUNT_DEF];
    logic [NODE_W-1:0] ready_nodes [$];
    logic [NODE_W-1:0] n;
    logic              ok;
    logic              loop_left;
    res = {};
    case (op)
      OP_ADD_NODE: begin
        node_seen[a] = 1'b1;
        res = {res, mk_result(KIND_ACK, '0, 1'b1, 1'b0, 1'b1)};
      end
      OP_ADD_EDGE: begin
        ok = node_seen[a] && node_seen[b] && edge_from.size() < EDGE_CAPACITY_DEF;
        if (ok) begin
          edge_from = {edge_from, a};
          edge_to   = {edge_to, b};
          indegree[b]++;
        end
        res = {res, mk_result(KIND_ACK, '0, ok, 1'b0, 1'b1)};
      end
      OP_SORT: begin
        rem = indegree;
        for (int i = 0; i < NODE_COUNT_DEF; i++)
          if (node_seen[i] && rem[i] == 0) ready_nodes = {ready_nodes, NODE_W'(i)};
        while (ready_nodes.size() > 0) begin
          n = ready_nodes.pop_back();
          res = {res, mk_result(KIND_ORDER, n, 1'b0, 1'b0, 1'b0)};
          foreach (edge_from[e]) begin
            if (edge_from[e] == n && rem[edge_to[e]] != 0) begin
              rem[edge_to[e]]--;
              if (rem[edge_to[e]] == 0) ready_nodes = {ready_nodes, edge_to[e]};
            end
          end
        end
        loop_left = 1'b0;
        for (int i = 0; i < NODE_COUNT_DEF; i++)
          if (node_seen[i] && rem[i] != 0) loop_left = 1'b1;
        res = {res, mk_result(KIND_STATUS, '0, 1'b0, loop_left, 1'b1)};
      end
      default: begin
        res = {res, mk_result(KIND_ACK, '0, 1'b0, 1'b0, 1'b1)};
      end
    endcase
  endfunction

  // mostly back to back, some short gaps, a few long ones
  function automatic int unsigned idle_gap(bit calm);
    if (calm) return 0;
    case ($urandom_range(0, 15))
      0: return $urandom_range(8, 30);
      1, 2, 3, 4: return $urandom_range(1, 3);
      default: return 0;
    endcase
  endfunction

  task automatic issue_cmd(input logic [OP_W-1:0] op, input logic [NODE_W-1:0] a, b,
                           input bit typed, input result_t want);
    result_q_t   outcome;
    int unsigned gap;
    cmd_if.valid     <= 1'b1;
    cmd_if.operation <= op;
    cmd_if.node_a    <= a;
    cmd_if.node_b    <= b;
    do @(posedge clk_i); while (!cmd_if.ready);
    kahn_predict(op, a, b, outcome);
    if (typed) pending_results = {pending_results, want};
    else pending_results = {pending_results, outcome};
    if ($urandom_range(0, 39) == 0) calm_tx = !calm_tx;
    gap = idle_gap(calm_tx);
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  initial begin : stimulus
    int unsigned       pick;
    int unsigned       i;
    int unsigned       j;
    logic [NODE_W-1:0] a;
    logic [NODE_W-1:0] b;
    logic [NODE_W-1:0] tmp;
    logic [NODE_W-1:0] cand [$];
    rst_ni           <= 1'b0;
    cmd_if.valid     <= 1'b0;
    cmd_if.operation <= OP_ADD_NODE;
    cmd_if.node_a    <= '0;
    cmd_if.node_b    <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[r])
      issue_cmd(directed_rows[r].op, directed_rows[r].a, directed_rows[r].b,
                directed_rows[r].typed, directed_rows[r].want);

    // random node ranking; well-formed edges go from low to high rank
    for (int k = 0; k < NODE_COUNT_DEF; k++) topo_rank[k] = NODE_W'(k);
    for (int k = NODE_COUNT_DEF - 1; k > 0; k--) begin
      j = $urandom_range(0, k);
      tmp = topo_rank[k];
      topo_rank[k] = topo_rank[j];
      topo_rank[j] = tmp;
    end

    repeat (RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      a = NODE_W'($urandom_range(0, 15));
      b = NODE_W'($urandom_range(0, 15));
      if (pick < 4) begin
        issue_cmd(OP_UNKNOWN, a, b, 1'b0, ACK_REFUSED);
      end else if (pick < 30) begin
        issue_cmd(OP_ADD_NODE, a, b, 1'b0, ACK_REFUSED);
      end else if (pick < 70) begin
        cand = {};
        for (int n = 0; n < NODE_COUNT_DEF; n++)
          if (node_seen[n] && NODE_W'(n) != LOOP_NODE) cand = {cand, NODE_W'(n)};
        // a few edges stay fully random: absent ends, back edges, repeats
        if (cand.size() >= 2 && $urandom_range(0, 11) != 0) begin
          i = $urandom_range(0, cand.size() - 1);
          j = $urandom_range(0, cand.size() - 2);
          if (j >= i) j++;
          a = cand[i];
          b = cand[j];
          if (topo_rank[a] > topo_rank[b]) begin
            tmp = a;
            a = b;
            b = tmp;
          end
        end
        issue_cmd(OP_ADD_EDGE, a, b, 1'b0, ACK_REFUSED);
      end else begin
        issue_cmd(OP_SORT, a, b, 1'b0, ACK_REFUSED);
      end
    end
    cmd_if.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin : sink_side
    int unsigned stall_left;
    int unsigned taken;
    bit          calm_rx;
    bit          choked;
    stall_left = 0;
    taken      = 0;
    calm_rx    = 1'b0;
    choked     = 1'b0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (res_if.valid && res_if.ready) taken++;
      if ($urandom_range(0, 63) == 0) calm_rx = !calm_rx;
      // one long hold-off so the output queue fills and commands back up
      if (!choked && taken >= CHOKE_AFTER) begin
        choked = 1'b1;
        stall_left = CHOKE_CYCLES;
      end else if (stall_left == 0) begin
        stall_left = idle_gap(calm_rx);
      end
      if (stall_left > 0) begin
        res_if.ready <= 1'b0;
        stall_left--;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got.kind       = kind_e'(res_if.kind);
      got.node_index = res_if.node_index;
      got.accepted   = res_if.accepted;
      got.cyclic     = res_if.cyclic;
      got.is_last    = res_if.is_last;
      if (pending_results.size() == 0) begin
        mismatch_cnt++;
        $display("%0t: unexpected item kind %0d node %0d acc %b cyc %b last %b",
                 $time, got.kind, got.node_index, got.accepted, got.cyclic, got.is_last);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatch_cnt++;
          $display("%0t: expected kind %0d node %0d acc %b cyc %b last %b,",
                   $time, want.kind, want.node_index, want.accepted, want.cyclic,
                   want.is_last, " got kind %0d node %0d acc %b cyc %b last %b",
                   got.kind, got.node_index, got.accepted, got.cyclic, got.is_last);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d items still expected", $time, pending_results.size());
      $display("Mismatches found");
      $finish;
    end
  end

endmodule

// ===== sim.f =====
rtl/core/tsk_pkg.sv
rtl/core/tsk_in_if.sv
rtl/core/tsk_out_if.sv
rtl/core/topological_sort_kahn.sv
tb/sv/tb_top.sv
